### rtl/rpq_pkg.sv
package rpq_pkg;

    localparam int FIELD_CNT_W = 5;

    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_QUERY  = 2'd1,
        ACT_REMOVE = 2'd2,
        ACT_FIND   = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_SCAN,
        FSM_COMPACT
    } fsm_t;

    typedef struct packed {
        action_t     action;
        logic [31:0] name_key;
        logic [9:0]  score;
        logic [7:0]  priority_req;
    } request_t;

    typedef struct packed {
        status_t                  status;
        logic [7:0]               max_priority;
        logic [FIELD_CNT_W-1:0]   removed_count;
        logic [31:0]              found_name;
        logic [9:0]               found_score;
        logic [7:0]               found_priority;
        logic [FIELD_CNT_W-1:0]   entry_total;
    } result_t;

    typedef struct packed {
        logic [31:0] name;
        logic [9:0]  score;
        logic [7:0]  prio;
    } entry_t;

endpackage

### rtl/record_priority_queue_unit.sv
// Insert completes straight from idle; query and find scan the held records, find ends early on a match;
// remove scans, then compacts the table in a second pass. Table empty/full cases complete from idle.
// Throughput: busy drops in the cycle the result strobe is high, so the next transaction
// is taken in that cycle; back-to-back inserts run at one per cycle.
// Busy is high for the whole scan; the result strobe is never stalled. The table is one
// registered-read memory. Reset clears the record count; the table needs no clearing.
module record_priority_queue_unit
    import rpq_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  request_t request,
    output logic     done,
    output result_t  result
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    function automatic logic [FIELD_CNT_W-1:0] to_field(logic [CW-1:0] v);
        logic [CW+FIELD_CNT_W-1:0] ext;
        ext = {{FIELD_CNT_W{1'b0}}, v};
        return ext[FIELD_CNT_W-1:0];
    endfunction

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    fsm_t          state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic          pend_reg, pend_next;
    logic [CW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CW-1:0] removed_reg, removed_next;
    logic [7:0]    max_reg, max_next;
    action_t       act_reg, act_next;
    logic [31:0]   key_reg, key_next;
    logic          done_reg, done_next;
    result_t       result_reg, result_next;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    entry_t        wr_data;
    logic [AW-1:0] rd_addr;
    logic          issue;
    logic          last;
    logic [7:0]    max_upd;

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg   <= FSM_IDLE;
            count_reg   <= '0;
            idx_reg     <= '0;
            pend_reg    <= 1'b0;
            wr_ptr_reg  <= '0;
            removed_reg <= '0;
            max_reg     <= '0;
            act_reg     <= ACT_INSERT;
            done_reg    <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            idx_reg     <= idx_next;
            pend_reg    <= pend_next;
            wr_ptr_reg  <= wr_ptr_next;
            removed_reg <= removed_next;
            max_reg     <= max_next;
            act_reg     <= act_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk) begin
        key_reg    <= key_next;
        result_reg <= result_next;
    end

    assign issue   = (idx_reg < count_reg);
    assign last    = pend_reg && (idx_reg == count_reg);
    assign max_upd = (rd_data_reg.prio > max_reg) ? rd_data_reg.prio : max_reg;

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        pend_next    = 1'b0;
        wr_ptr_next  = wr_ptr_reg;
        removed_next = removed_reg;
        max_next     = max_reg;
        act_next     = act_reg;
        key_next     = key_reg;
        done_next    = 1'b0;
        result_next  = result_reg;
        wr_en        = 1'b0;
        wr_addr      = wr_ptr_reg[AW-1:0];
        wr_data      = rd_data_reg;
        rd_addr      = idx_reg[AW-1:0];

        unique case (state_reg)
            FSM_IDLE: begin
                if (start) begin
                    act_next    = request.action;
                    key_next    = request.name_key;
                    result_next = '0;
                    unique case (request.action)
                        ACT_INSERT: begin
                            done_next = 1'b1;
                            if (count_reg == CW'(DEPTH)) begin
                                result_next.status      = ST_FULL;
                                result_next.entry_total = to_field(count_reg);
                            end else begin
                                wr_en                   = 1'b1;
                                wr_addr                 = count_reg[AW-1:0];
                                wr_data.name            = request.name_key;
                                wr_data.score           = request.score;
                                wr_data.prio            = request.priority_req;
                                count_next              = count_reg + 1'b1;
                                result_next.status      = ST_OK;
                                result_next.entry_total = to_field(count_next);
                            end
                        end
                        ACT_QUERY, ACT_REMOVE, ACT_FIND: begin
                            if (count_reg == '0) begin
                                done_next          = 1'b1;
                                result_next.status = ST_EMPTY;
                            end else begin
                                state_next = FSM_SCAN;
                                idx_next   = '0;
                                max_next   = '0;
                            end
                        end
                    endcase
                end
            end

            FSM_SCAN: begin
                if (issue) begin
                    idx_next  = idx_reg + 1'b1;
                    pend_next = 1'b1;
                end
                if (pend_reg) begin
                    if (act_reg == ACT_FIND) begin
                        if (rd_data_reg.name == key_reg) begin
                            state_next                 = FSM_IDLE;
                            done_next                  = 1'b1;
                            result_next                = '0;
                            result_next.status         = ST_OK;
                            result_next.found_name     = rd_data_reg.name;
                            result_next.found_score    = rd_data_reg.score;
                            result_next.found_priority = rd_data_reg.prio;
                            result_next.entry_total    = to_field(count_reg);
                        end else if (last) begin
                            state_next              = FSM_IDLE;
                            done_next               = 1'b1;
                            result_next             = '0;
                            result_next.status      = ST_NOT_FOUND;
                            result_next.entry_total = to_field(count_reg);
                        end
                    end else begin
                        max_next = max_upd;
                        if (last) begin
                            if (act_reg == ACT_REMOVE) begin
                                // second pass: drop max-priority records, pack the rest down
                                state_next   = FSM_COMPACT;
                                idx_next     = '0;
                                pend_next    = 1'b0;
                                wr_ptr_next  = '0;
                                removed_next = '0;
                            end else begin
                                state_next               = FSM_IDLE;
                                done_next                = 1'b1;
                                result_next              = '0;
                                result_next.status       = ST_OK;
                                result_next.max_priority = max_upd;
                                result_next.entry_total  = to_field(count_reg);
                            end
                        end
                    end
                end
            end

            FSM_COMPACT: begin
                if (issue) begin
                    idx_next  = idx_reg + 1'b1;
                    pend_next = 1'b1;
                end
                if (pend_reg) begin
                    // write pointer trails the read index, so no same-entry overlap
                    if (rd_data_reg.prio == max_reg) begin
                        removed_next = removed_reg + 1'b1;
                    end else begin
                        wr_en       = 1'b1;
                        wr_ptr_next = wr_ptr_reg + 1'b1;
                    end
                    if (last) begin
                        state_next                = FSM_IDLE;
                        done_next                 = 1'b1;
                        count_next                = wr_ptr_next;
                        result_next               = '0;
                        result_next.status        = ST_OK;
                        result_next.max_priority  = max_reg;
                        result_next.removed_count = to_field(removed_next);
                        result_next.entry_total   = to_field(wr_ptr_next);
                    end
                end
            end

            default: begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    assign busy   = (state_reg != FSM_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule

### sim/rpq_checker.sv
module rpq_checker
    import rpq_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  logic     busy,
    input  request_t request,
    input  logic     done,
    input  result_t  result,
    output int       errors,
    output int       pending
);

    // shadow copy of the record table, insertion order
    entry_t      records [DEPTH];
    int unsigned held = 0;
    result_t     expected_results [$];

    initial
    begin
        errors  = 0;
        pending = 0;
    end

    task automatic flag_error(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        errors++;
    endtask

    task automatic check_field(input string field, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            flag_error($sformatf("%s got %0h, want %0h", field, got, want));
    endtask

    function automatic logic [7:0] top_priority();
        logic [7:0] best;
        best = '0;
        for (int i = 0; i < held; i++)
            if (records[i].prio > best)
                best = records[i].prio;
        return best;
    endfunction

    // updates the shadow table and returns the result the unit must produce
    function automatic result_t queue_outcome(input request_t req);
        result_t     res;
        logic [7:0]  top;
        int unsigned kept;
        bit          hit;
        res  = '0;
        kept = 0;
        hit  = 1'b0;
        case (req.action)
            ACT_INSERT:
            begin
                if (held >= DEPTH)
                    res.status = ST_FULL;
                else
                begin
                    records[held] = '{name: req.name_key, score: req.score,
                                      prio: req.priority_req};
                    held++;
                end
            end
            ACT_QUERY:
            begin
                if (held == 0)
                    res.status = ST_EMPTY;
                else
                    res.max_priority = top_priority();
            end
            ACT_REMOVE:
            begin
                if (held == 0)
                    res.status = ST_EMPTY;
                else
                begin
                    top = top_priority();
                    res.max_priority = top;
                    for (int i = 0; i < held; i++)
                    begin
                        if (records[i].prio == top)
                            res.removed_count++;
                        else
                        begin
                            records[kept] = records[i];
                            kept++;
                        end
                    end
                    held = kept;
                end
            end
            default:
            begin
                if (held == 0)
                    res.status = ST_EMPTY;
                else
                begin
                    res.status = ST_NOT_FOUND;
                    for (int i = 0; i < held; i++)
                    begin
                        if (!hit && records[i].name == req.name_key)
                        begin
                            hit                = 1'b1;
                            res.status         = ST_OK;
                            res.found_name     = records[i].name;
                            res.found_score    = records[i].score;
                            res.found_priority = records[i].prio;
                        end
                    end
                end
            end
        endcase
        res.entry_total = held[FIELD_CNT_W-1:0];
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            held = 0;
            expected_results.delete();
        end
        else
        begin
            // retire first: a result may land in the same cycle as the next transaction
            if (done)
            begin
                if (expected_results.size() == 0)
                    flag_error("result strobe with no transaction outstanding");
                else
                begin
                    want = expected_results.pop_front();
                    check_field("status", 32'(result.status), 32'(want.status));
                    check_field("max_priority", 32'(result.max_priority),
                                32'(want.max_priority));
                    check_field("removed_count", 32'(result.removed_count),
                                32'(want.removed_count));
                    check_field("found_name", result.found_name, want.found_name);
                    check_field("found_score", 32'(result.found_score),
                                32'(want.found_score));
                    check_field("found_priority", 32'(result.found_priority),
                                32'(want.found_priority));
                    check_field("entry_total", 32'(result.entry_total),
                                32'(want.entry_total));
                end
            end
            if (start && !busy)
                expected_results.push_back(queue_outcome(request));
        end
        pending = expected_results.size();
    end

endmodule

### sim/tb.sv
module tb;
    import rpq_pkg::*;

    localparam int DEPTH        = 16;
    localparam int RANDOM_ITEMS = 1725;
    localparam int STALL_LIMIT  = 4000;

    logic     clk;
    logic     rst_n;
    logic     start;
    logic     busy;
    logic     done;
    request_t request;
    result_t  result;
    int       errors;
    int       pending;
    int       idle_cycles;

    logic [31:0] recent_names [16];
    int          name_slot;
    bit          filling;

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    record_priority_queue_unit #(.DEPTH(DEPTH)) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result)
    );

    rpq_checker #(.DEPTH(DEPTH)) scoreboard (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result),
        .errors  (errors),
        .pending (pending)
    );

    // watchdog: cycles without any accepted transaction or result
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    function automatic request_t make_request(input action_t act, input logic [31:0] key,
                                              input logic [9:0] scr, input logic [7:0] prio);
        request_t r;
        r.action       = act;
        r.name_key     = key;
        r.score        = scr;
        r.priority_req = prio;
        return r;
    endfunction

    function automatic request_t random_request(input bit fill_bias);
        request_t r;
        int       pick;
        r.name_key     = $urandom();
        r.score        = 10'($urandom_range(1023));
        r.priority_req = $urandom_range(1) ? 8'($urandom_range(7)) : 8'($urandom_range(255));
        pick           = $urandom_range(99);
        if (pick < (fill_bias ? 65 : 25))
            r.action = ACT_INSERT;
        else if (pick < (fill_bias ? 75 : 40))
            r.action = ACT_QUERY;
        else if (pick < (fill_bias ? 82 : 75))
            r.action = ACT_REMOVE;
        else
            r.action = ACT_FIND;
        // small key pool gives duplicate names, so find must pick the oldest
        if (r.action == ACT_INSERT && $urandom_range(3) == 0)
            r.name_key = $urandom_range(7);
        if (r.action == ACT_FIND && $urandom_range(3) != 0)
            r.name_key = recent_names[$urandom_range(15)];
        return r;
    endfunction

    // holds the transaction on the bus until the unit takes it
    task automatic issue(input request_t r);
        @(negedge clk);
        start   = 1'b1;
        request = r;
        do
            @(posedge clk);
        while (busy);
        if (r.action == ACT_INSERT)
        begin
            recent_names[name_slot] = r.name_key;
            name_slot = (name_slot + 1) % 16;
        end
    endtask

    task automatic hold_off(input int cycles);
        @(negedge clk);
        start = 1'b0;
        repeat (cycles - 1)
            @(negedge clk);
    endtask

    task automatic drain();
        @(negedge clk);
        start = 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    initial
    begin
        start     = 1'b0;
        request   = '0;
        rst_n     = 1'b0;
        name_slot = 0;
        filling   = 1'b1;
        foreach (recent_names[i])
            recent_names[i] = '0;
        repeat (9)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // empty table
        issue(make_request(ACT_QUERY,  '0, '0, '0));
        issue(make_request(ACT_REMOVE, '0, '0, '0));
        issue(make_request(ACT_FIND,   '0, '0, '0));
        // fill to capacity, several records share the top priority
        issue(make_request(ACT_INSERT, 32'h0000_0000, 10'h000, 8'h00));
        issue(make_request(ACT_INSERT, 32'hFFFF_FFFF, 10'h3FF, 8'hFF));
        for (int i = 2; i < DEPTH; i++)
            issue(make_request(ACT_INSERT, 32'h0101_0101 * i, 10'(i * 61),
                               (i % 5 == 0) ? 8'hFF : 8'(i * 13)));
        // full table rejects the insert
        issue(make_request(ACT_INSERT, 32'hA5A5_A5A5, 10'h155, 8'h80));
        issue(make_request(ACT_FIND,   32'hFFFF_FFFF, '0, '0));
        issue(make_request(ACT_FIND,   32'h0000_0000, '0, '0));
        issue(make_request(ACT_FIND,   32'h1234_5678, '0, '0));
        issue(make_request(ACT_QUERY,  '0, '0, '0));
        issue(make_request(ACT_REMOVE, '0, '0, '0));
        drain();

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if ($urandom_range(29) == 0)
                filling = !filling;
            issue(random_request(filling));
            if (n % 300 == 299)
                drain();
            else if ((n < 700 || n > 1000) && $urandom_range(99) < 21)
                hold_off($urandom_range(1, 40));
        end

        drain();
        repeat (40)
            @(posedge clk);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
